@@ hw/rtl/bds_pkg.sv @@
// Shared constants, types and the per-byte rounding average for the 2x2 box downsampler.
// No dependencies; every other file imports this package.
package bds_pkg;

  localparam int MAX_OUT_WIDTH = 1024;
  localparam int PIX_W         = 32;
  localparam int CNT_W         = 11;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 11;
  localparam int LS_DEPTH      = 2 * MAX_OUT_WIDTH;
  localparam int ADDR_W        = $clog2(LS_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_WIDTH  = 1'b0,
    REG_OUT_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              row_odd;
    logic              col_odd;
    logic              row_last;
    logic              frame_last;
  } bds_ctrl_t;

  function automatic logic [PIX_W-1:0] avg_bytes(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] diff;
    diff = (a ^ b) & 32'hFEFE_FEFE;
    return (a | b) - (diff >> 1);
  endfunction

endpackage

@@ hw/rtl/bds_in_if.sv @@
// Input item channel: valid/ready with one source pixel.
// Depends on bds_pkg.
interface bds_in_if;
  import bds_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

@@ hw/rtl/bds_out_if.sv @@
// Result item channel: valid/ready with the averaged pixel and row/frame end flags.
// Depends on bds_pkg.
interface bds_out_if;
  import bds_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             row_end;
  logic             frame_end;
  modport source (output valid, output pixel_out, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input pixel_out, input row_end, input frame_end,
                  output ready);
endinterface

@@ hw/rtl/bds_cfg_if.sv @@
// Configuration write channel: valid/ready with register index and write data.
// Depends on bds_pkg.
interface bds_cfg_if;
  import bds_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/bds_ctrl.sv @@
// Raster position tracking: source column/row phase and output column/row counters.
// Produces line store address and row/frame end flags per item. Depends on bds_pkg.
module bds_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           advance,
  input  logic [bds_pkg::CNT_W-1:0]      out_width,
  input  logic [bds_pkg::CNT_W-1:0]      out_height,
  output bds_pkg::bds_ctrl_t             ctrl
);
  import bds_pkg::*;

  logic [CNT_W-1:0] column_count_r, column_count_nxt;
  logic [CNT_W-1:0] row_count_r, row_count_nxt;
  logic             col_phase_r, col_phase_nxt;
  logic             row_phase_r, row_phase_nxt;
  logic [CNT_W-1:0] w_eff, h_eff;
  logic             col_last, row_cnt_last;
  logic [CNT_W:0]   idx_full;

  always_comb begin
    if (out_width == '0) begin
      w_eff = CNT_W'(1);
    end else if (32'(out_width) > MAX_OUT_WIDTH) begin
      w_eff = CNT_W'(MAX_OUT_WIDTH);
    end else begin
      w_eff = out_width;
    end
    h_eff = (out_height == '0) ? CNT_W'(1) : out_height;
    col_last     = column_count_r >= (w_eff - CNT_W'(1));
    row_cnt_last = row_count_r >= (h_eff - CNT_W'(1));
    idx_full     = {column_count_r, col_phase_r};
  end

  always_comb begin
    if (32'(idx_full) >= LS_DEPTH) begin
      ctrl.addr = ADDR_W'(LS_DEPTH - 1);
    end else begin
      ctrl.addr = ADDR_W'(idx_full);
    end
    ctrl.row_odd    = row_phase_r;
    ctrl.col_odd    = col_phase_r;
    ctrl.row_last   = col_last;
    ctrl.frame_last = col_last && row_cnt_last;
  end

  always_comb begin
    column_count_nxt = column_count_r;
    row_count_nxt    = row_count_r;
    col_phase_nxt    = ~col_phase_r;
    row_phase_nxt    = row_phase_r;
    if (col_phase_r) begin
      if (col_last) begin
        column_count_nxt = '0;
        row_phase_nxt    = ~row_phase_r;
        if (row_phase_r) begin
          row_count_nxt = row_cnt_last ? '0 : CNT_W'(row_count_r + CNT_W'(1));
        end
      end else begin
        column_count_nxt = CNT_W'(column_count_r + CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      row_count_r    <= '0;
      col_phase_r    <= 1'b0;
      row_phase_r    <= 1'b0;
    end else if (advance) begin
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
      col_phase_r    <= col_phase_nxt;
      row_phase_r    <= row_phase_nxt;
    end
  end

`ifndef SYNTHESIS
  a_even_col_holds_counts: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !col_phase_r |=> $stable(column_count_r) && $stable(row_count_r))
    else $error("counters moved on an even source column");

  a_row_phase_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !(col_phase_r && col_last) |=> $stable(row_phase_r))
    else $error("row phase toggled away from a row end");

  a_row_count_on_odd_row: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !row_phase_r |=> $stable(row_count_r))
    else $error("row count moved during an even source row");
`endif

endmodule

@@ hw/rtl/box_downsample_2x2_rgba.sv @@
// Top level of the 2x2 box downsampler for RGBA8888 streams.
// Depends on bds_pkg, bds_in_if, bds_out_if, bds_cfg_if and bds_ctrl.
//
// Usage:
//   in_ch  : source pixels in raster order, rows of 2*out_width pixels,
//            frames of 2*out_height rows.
//   out_ch : one averaged pixel per 2x2 block, with row_end on the last
//            pixel of an output row and frame_end on the last of the frame.
//   cfg_ch : index 0 writes out_width, index 1 writes out_height; always ready.
//            Write only while no items are in flight.
// Throughput: one item per cycle unless out_ch stalls. The line store is a
//   single-port memory: even rows write it, odd rows read it, one access per accepted item.
// Pipeline: accepting the last source pixel of a block loads the read stage,
//   and the result register then loads the averaged pixel and marks it valid.
// Stall: when out_ch is not taken, the whole pipe holds and in_ch.ready drops;
//   the result register holds its item until accepted.
// Reset: counters restart at the frame origin, sizes return to 1, no result
//   is pending. Line store contents are not cleared.
module box_downsample_2x2_rgba (
  input  logic       clk,
  input  logic       rst_n,
  bds_in_if.sink     in_ch,
  bds_out_if.source  out_ch,
  bds_cfg_if.sink    cfg_ch
);
  import bds_pkg::*;

  logic [PIX_W-1:0]  line_store [LS_DEPTH];
  logic [CNT_W-1:0]  out_width_r;
  logic [CNT_W-1:0]  out_height_r;
  bds_ctrl_t         ctrl;
  bds_ctrl_t         s1_ctrl_r;
  logic              s1_valid_r;
  logic [PIX_W-1:0]  s1_px_r;
  logic [PIX_W-1:0]  rd_r;
  logic [PIX_W-1:0]  held_r;
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_px_r;
  logic              out_row_end_r;
  logic              out_frame_end_r;
  logic              pipe_en;
  logic              accept;
  logic              s1_fire;
  logic [PIX_W-1:0]  vm;
  logic [PIX_W-1:0]  res;

  assign pipe_en      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = pipe_en;
  assign accept       = in_ch.valid && pipe_en;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pixel_out = out_px_r;
  assign out_ch.row_end   = out_row_end_r;
  assign out_ch.frame_end = out_frame_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_width_r  <= CNT_W'(1);
      out_height_r <= CNT_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_OUT_WIDTH:  out_width_r  <= cfg_ch.data;
        REG_OUT_HEIGHT: out_height_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  bds_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (accept),
    .out_width  (out_width_r),
    .out_height (out_height_r),
    .ctrl       (ctrl)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      if (ctrl.row_odd) begin
        rd_r <= line_store[ctrl.addr];
      end else begin
        line_store[ctrl.addr] <= in_ch.pixel_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r   <= in_ch.pixel_in;
      s1_ctrl_r <= ctrl;
    end
  end

  assign vm      = avg_bytes(rd_r, s1_px_r);
  assign res     = avg_bytes(held_r, vm);
  assign s1_fire = s1_valid_r && pipe_en && s1_ctrl_r.row_odd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (s1_fire && !s1_ctrl_r.col_odd) begin
      held_r <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= s1_valid_r && s1_ctrl_r.row_odd && s1_ctrl_r.col_odd;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_ctrl_r.col_odd) begin
      out_px_r        <= res;
      out_row_end_r   <= s1_ctrl_r.row_last;
      out_frame_end_r <= s1_ctrl_r.frame_last;
    end
  end

`ifndef SYNTHESIS
  a_frame_end_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_end_r |-> out_row_end_r)
    else $error("frame end without row end");

  a_odd_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && pipe_en && s1_ctrl_r.row_odd && s1_ctrl_r.col_odd |=> out_valid_r)
    else $error("odd row, odd column item gave no result");

  a_even_item_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_en && !(s1_valid_r && s1_ctrl_r.row_odd && s1_ctrl_r.col_odd) |=> !out_valid_r)
    else $error("result appeared without an odd row, odd column item");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(s1_valid_r) && $stable(s1_px_r) && $stable(rd_r))
    else $error("read stage moved during a stall");
`endif

endmodule
